// File: src/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the sync/length/checksum frame receiver.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Default payload buffer depth
  localparam int PAYLOAD_DEPTH_DEF = 64;

  // Reset values of the configuration registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFB;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hFC;
  localparam logic [5:0] MAX_LENGTH_RST  = 6'd63;

  // Type bytes at or above this value abort the frame
  localparam logic [7:0] TYPE_LIMIT = 8'hF1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_CSUM_ERR = 1'b1;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] frame_type;
    logic [5:0] frame_length;
    logic [5:0] byte_index;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

endpackage

// File: src/slcd_ram.sv
// ----------------------------------------------------------------------------
// slcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slcd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/sync_length_checksum_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Hunts for sync/type/length/payload/checksum frames in a byte stream,
// buffers the payload and replays it when the checksum matches.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in_      | sink      | in_tvalid/in_tready  | tdata: rx_byte
//  out_     | source    | out_tvalid/out_tready| tdata, tuser: kind, tlast: last
//  cfg_     | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  Header, sync, type, length and payload bytes are taken one per cycle while
//  intake is not paused. A good frame pauses intake while its payload is read
//  back from the buffer RAM, one entry per cycle while room allows.
//  The check byte is taken only when the output buffer has room for a result.
//  The output register and a skid entry let intake continue while a result
//  waits; out_tready low throttles the buffer read-back.
//  rst_n is synchronous; the payload RAM holds no reset and needs no clearing.
//
module sync_length_checksum_deframer_core #(
  parameter int PAYLOAD_DEPTH = slcd_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] frame_type, [13:8] frame_length,
                                  // [19:14] byte_index, [27:20] data_byte
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  import slcd_pkg::*;

  localparam int AddrW = $clog2(PAYLOAD_DEPTH);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(PAYLOAD_DEPTH - 1);

  // Configuration
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic [5:0] max_length_r;

  // Parser state
  phase_t     phase_r, phase_nxt;
  logic [5:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] held_type_r, held_type_nxt;
  logic [5:0] held_length_r, held_length_nxt;
  logic [AddrW-1:0] wr_slot_r, wr_slot_nxt;

  // Read-back state
  logic             emit_r, emit_nxt;
  logic [5:0]       emit_idx_r, emit_idx_nxt;
  logic [AddrW-1:0] rd_slot_r, rd_slot_nxt;

  // Result pipeline: read stage, output register, skid entry
  logic    rd_v_r, rd_v_nxt;
  logic    rd_ram_r, rd_ram_nxt;
  result_t rd_res_r, rd_res_nxt;
  logic    out_v_r, out_v_nxt;
  result_t out_r, out_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t skid_r, skid_nxt;

  logic [7:0] rx_byte;
  logic       in_acc;
  logic       pop;
  logic [1:0] occ;
  logic       issue_ok;
  logic       emit_issue;
  logic       ram_we;
  logic [7:0] ram_q;
  result_t    rd_full;

  assign rx_byte = in_tdata;
  assign in_acc  = in_tvalid & in_tready;
  assign pop     = out_v_r & out_tready;

  // Room check: results in flight after this cycle must fit out + skid
  assign occ      = {1'b0, out_v_r} + {1'b0, skid_v_r} + {1'b0, rd_v_r};
  assign issue_ok = (occ - {1'b0, pop}) <= 2'd1;

  assign in_tready  = ~emit_r & ((phase_r != PH_CHECK) | issue_ok);
  assign emit_issue = emit_r & issue_ok;
  assign cfg_ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      max_length_r  <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        CFG_MAX_LENGTH:  max_length_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SYNC1;
      bytes_left_r  <= '0;
      sum_r         <= '0;
      held_type_r   <= '0;
      held_length_r <= '0;
      wr_slot_r     <= '0;
    end else begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      sum_r         <= sum_nxt;
      held_type_r   <= held_type_nxt;
      held_length_r <= held_length_nxt;
      wr_slot_r     <= wr_slot_nxt;
    end
  end

  // Parser next state; start read-back or post an error on the check byte
  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    sum_nxt         = sum_r;
    held_type_nxt   = held_type_r;
    held_length_nxt = held_length_r;
    wr_slot_nxt     = wr_slot_r;
    ram_we          = 1'b0;
    emit_nxt        = emit_r;
    emit_idx_nxt    = emit_idx_r;
    rd_slot_nxt     = rd_slot_r;
    rd_v_nxt        = 1'b0;
    rd_ram_nxt      = 1'b0;
    rd_res_nxt      = rd_res_r;

    if (in_acc) begin
      case (phase_r)
        PH_SYNC2: begin
          if (rx_byte == sync_second_r) begin
            sum_nxt   = sum_r + rx_byte;
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_TYPE: begin
          if (rx_byte != 8'd0 && rx_byte < TYPE_LIMIT) begin
            held_type_nxt = rx_byte;
            sum_nxt       = sum_r + rx_byte;
            phase_nxt     = PH_LEN;
          end else begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_LEN: begin
          if (rx_byte != 8'd0 && rx_byte <= {2'b00, max_length_r}) begin
            held_length_nxt = rx_byte[5:0];
            bytes_left_nxt  = rx_byte[5:0];
            wr_slot_nxt     = '0;
            sum_nxt         = sum_r + rx_byte;
            phase_nxt       = PH_DATA;
          end else begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_DATA: begin
          ram_we         = 1'b1;
          wr_slot_nxt    = (wr_slot_r == LastSlot) ? '0 : wr_slot_r + 1'b1;
          sum_nxt        = sum_r + rx_byte;
          bytes_left_nxt = bytes_left_r - 6'd1;
          if (bytes_left_r == 6'd1) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_SYNC1;
          if (rx_byte == sum_r) begin
            emit_nxt     = 1'b1;
            emit_idx_nxt = '0;
            rd_slot_nxt  = '0;
          end else begin
            rd_v_nxt                = 1'b1;
            rd_res_nxt.kind         = KIND_CSUM_ERR;
            rd_res_nxt.frame_type   = held_type_r;
            rd_res_nxt.frame_length = held_length_r;
            rd_res_nxt.byte_index   = '0;
            rd_res_nxt.data_byte    = rx_byte;
            rd_res_nxt.last         = 1'b1;
          end
        end
        default: begin
          if (rx_byte == sync_first_r) begin
            sum_nxt   = rx_byte;
            phase_nxt = PH_SYNC2;
          end else begin
            phase_nxt = PH_SYNC1;
          end
        end
      endcase
    end

    // Read one buffered payload byte per cycle while room allows
    if (emit_issue) begin
      rd_v_nxt                = 1'b1;
      rd_ram_nxt              = 1'b1;
      rd_res_nxt.kind         = KIND_PAYLOAD;
      rd_res_nxt.frame_type   = held_type_r;
      rd_res_nxt.frame_length = held_length_r;
      rd_res_nxt.byte_index   = emit_idx_r;
      rd_res_nxt.data_byte    = '0;
      rd_res_nxt.last         = (emit_idx_r + 6'd1) == held_length_r;
      emit_idx_nxt            = emit_idx_r + 6'd1;
      rd_slot_nxt             = (rd_slot_r == LastSlot) ? '0 : rd_slot_r + 1'b1;
      if ((emit_idx_r + 6'd1) == held_length_r) begin
        emit_nxt = 1'b0;
      end
    end
  end

  // Payload buffer
  slcd_ram #(
    .DATA_W (8),
    .DEPTH  (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_slot_r),
    .wr_data (rx_byte),
    .rd_en   (emit_issue),
    .rd_addr (rd_slot_r),
    .rd_data (ram_q)
  );

  // Merge RAM data into the read-stage result
  always_comb begin
    rd_full = rd_res_r;
    if (rd_ram_r) begin
      rd_full.data_byte = ram_q;
    end
  end

  // Move results into the output register, overflow into the skid entry
  always_comb begin
    out_v_nxt  = out_v_r & ~pop;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = rd_v_r;
        skid_nxt   = rd_full;
      end else if (rd_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = rd_full;
      end
    end else if (rd_v_r) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = rd_full;
    end
  end

  // Read-back and result pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r   <= 1'b0;
      rd_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      emit_r   <= emit_nxt;
      rd_v_r   <= rd_v_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload of the result pipeline
  always_ff @(posedge clk) begin
    emit_idx_r <= emit_idx_nxt;
    rd_slot_r  <= rd_slot_nxt;
    rd_ram_r   <= rd_ram_nxt;
    rd_res_r   <= rd_res_nxt;
    out_r      <= out_nxt;
    skid_r     <= skid_nxt;
  end

  // Output ports
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r.data_byte, out_r.byte_index,
                       out_r.frame_length, out_r.frame_type};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

// File: src/slcd_checker.sv
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A checksum error is a single, final result
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[19:14] == 6'd0))
    else $error("checksum error result malformed");

  // Payload index stays inside the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[19:14] < out_tdata[13:8])
    else $error("payload index beyond frame length");

  // Last marker sits on the final payload byte only
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tlast == ((out_tdata[19:14] + 6'd1) == out_tdata[13:8])))
    else $error("last marker misplaced");

endmodule

bind sync_length_checksum_deframer_core slcd_checker u_slcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
